// ===== hdl/tss_pkg.sv =====
// Shared types and constants for the timestamp stream statistics block.
// No dependencies; used by the core, its checker and the bench.
package tss_pkg;

  localparam int unsigned TS_W   = 48;
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned DMAX_W = 31;
  localparam int unsigned SUM_W  = 64;

  localparam logic signed [OFS_W-1:0] DELTA_MIN_INIT = 32'sh7FFF_FFFF;
  localparam logic        [CNT_W-1:0] CNT_SAT        = {CNT_W{1'b1}};

  typedef struct packed {
    logic                    start_of_stream;
    logic [TS_W-1:0]         decode_time;
    logic signed [OFS_W-1:0] comp_offset;
  } in_req_t;

  typedef struct packed {
    logic [TS_W-1:0]         comp_time;
    logic [TS_W-1:0]         pres_time;
    logic [CNT_W-1:0]        max_reorder_depth;
    logic signed [OFS_W-1:0] min_delta;
    logic [DMAX_W-1:0]       max_delta;
    logic signed [SUM_W-1:0] delta_sum;
    logic [CNT_W-1:0]        sample_count;
  } out_rsp_t;

endpackage

// ===== hdl/tss_stream_if.sv =====
// Valid/ready channel carrying one request of payload type T.
// Depends on nothing; the core uses it with tss_pkg types.
interface tss_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/timestamp_stream_statistics_core.sv =====
// Timestamp stream statistics core: composition/presentation times, reorder
// depth and presentation delta statistics. Depends on tss_pkg, tss_stream_if.
//
//   channel | dir | payload            | handshake
//   --------+-----+--------------------+-----------------------------
//   in_ch   | in  | tss_pkg::in_req_t  | valid/ready, one request/item
//   out_ch  | out | tss_pkg::out_rsp_t | valid/ready, one result/item
//
// Throughput is one request per cycle while results are drained; a request
// passes the input register, then the result/statistics register.
// rst_n is synchronous, active low; it clears the pipeline valids, the
// latched first offset and all statistics (minimum delta to 2^31-1).
// A stalled result holds; the input register keeps accepting while it is
// empty, or the result register is empty or being drained in the same cycle.
module timestamp_stream_statistics_core (
  input  logic         clk,
  input  logic         rst_n,
  tss_stream_if.sink   in_ch,
  tss_stream_if.source out_ch
);

  localparam int unsigned TS_W  = tss_pkg::TS_W;
  localparam int unsigned OFS_W = tss_pkg::OFS_W;
  localparam int unsigned CNT_W = tss_pkg::CNT_W;
  localparam int unsigned DM_W  = tss_pkg::DMAX_W;
  localparam int unsigned SUM_W = tss_pkg::SUM_W;

  // ---------------- handshake ----------------
  logic s1_vld_r;
  logic out_vld_r;
  logic adv;      // result register may take a new value
  logic in_rdy;
  logic in_acc;
  logic load;     // stage 1 moves into the result/statistics registers

  assign adv    = !out_vld_r || out_ch.ready;
  assign in_rdy = !s1_vld_r || adv;
  assign in_acc = in_ch.valid && in_rdy;
  assign load   = adv && s1_vld_r;

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld_r;

  // ---------------- stage 1: times ----------------
  // First offset is tracked here in request order. On a start request the
  // latched offset equals this request's offset, so pres_time = decode_time.
  logic [OFS_W-1:0] first_ofs_r;
  logic             s1_start_r;
  logic [TS_W-1:0]  s1_comp_r;
  logic [TS_W-1:0]  s1_pres_r;

  logic [TS_W-1:0] ofs_ext;
  logic [TS_W-1:0] first_ext;
  logic [TS_W-1:0] comp_nxt;
  logic [TS_W-1:0] pres_nxt;

  assign ofs_ext   = {{(TS_W-OFS_W){in_ch.data.comp_offset[OFS_W-1]}},
                      in_ch.data.comp_offset};
  assign first_ext = {{(TS_W-OFS_W){first_ofs_r[OFS_W-1]}}, first_ofs_r};
  assign comp_nxt  = in_ch.data.decode_time + ofs_ext;
  assign pres_nxt  = in_ch.data.start_of_stream ? in_ch.data.decode_time
                                                : comp_nxt - first_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      first_ofs_r <= '0;
    end else begin
      if (in_rdy) begin
        s1_vld_r <= in_ch.valid;
      end
      if (in_acc && in_ch.data.start_of_stream) begin
        first_ofs_r <= in_ch.data.comp_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start_r <= in_ch.data.start_of_stream;
      s1_comp_r  <= comp_nxt;
      s1_pres_r  <= pres_nxt;
    end
  end

  // ---------------- stage 2: statistics ----------------
  // The statistics registers double as the result register.
  logic [TS_W-1:0]         prev_comp_r,  prev_comp_nxt;
  logic [TS_W-1:0]         prev_pres_r,  prev_pres_nxt;
  logic [CNT_W-1:0]        run_len_r,    run_len_nxt;
  logic [CNT_W-1:0]        longest_r,    longest_nxt;
  logic signed [OFS_W-1:0] least_r,      least_nxt;
  logic [DM_W-1:0]         greatest_r,   greatest_nxt;
  logic signed [SUM_W-1:0] sum_r,        sum_nxt;
  logic [CNT_W-1:0]        count_r,      count_nxt;

  logic signed [OFS_W-1:0] delta;      // low 32 bits of the pres_time step
  logic                    decrease;
  logic [CNT_W-1:0]        run_inc;

  assign delta    = s1_pres_r[OFS_W-1:0] - prev_pres_r[OFS_W-1:0];
  assign decrease = prev_comp_r > s1_comp_r;
  assign run_inc  = (run_len_r == tss_pkg::CNT_SAT) ? run_len_r : run_len_r + 1'b1;

  always_comb begin
    prev_comp_nxt = s1_comp_r;
    prev_pres_nxt = s1_pres_r;
    count_nxt     = (count_r == tss_pkg::CNT_SAT) ? count_r : count_r + 1'b1;
    run_len_nxt   = run_len_r;
    longest_nxt   = longest_r;
    least_nxt     = least_r;
    greatest_nxt  = greatest_r;
    sum_nxt       = sum_r;
    if (s1_start_r) begin
      // no previous sample: clear and count this one
      run_len_nxt  = '0;
      longest_nxt  = '0;
      least_nxt    = tss_pkg::DELTA_MIN_INIT;
      greatest_nxt = '0;
      sum_nxt      = '0;
      count_nxt    = {{(CNT_W-1){1'b0}}, 1'b1};
    end else begin
      if (decrease) begin
        run_len_nxt = run_inc;
        if (run_inc > longest_r) begin
          longest_nxt = run_inc;
        end
      end else begin
        run_len_nxt = '0;
      end
      if (delta < least_r) begin
        least_nxt = delta;
      end
      // positive delta only; sign bit clear means it fits in 31 bits
      if (!delta[OFS_W-1] && (delta[DM_W-1:0] > greatest_r)) begin
        greatest_nxt = delta[DM_W-1:0];
      end
      sum_nxt = sum_r + {{(SUM_W-OFS_W){delta[OFS_W-1]}}, delta};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      prev_comp_r <= '0;
      prev_pres_r <= '0;
      run_len_r   <= '0;
      longest_r   <= '0;
      least_r     <= tss_pkg::DELTA_MIN_INIT;
      greatest_r  <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else begin
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (load) begin
        prev_comp_r <= prev_comp_nxt;
        prev_pres_r <= prev_pres_nxt;
        run_len_r   <= run_len_nxt;
        longest_r   <= longest_nxt;
        least_r     <= least_nxt;
        greatest_r  <= greatest_nxt;
        sum_r       <= sum_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  // result fields are the freshly updated state
  assign out_ch.data.comp_time         = prev_comp_r;
  assign out_ch.data.pres_time         = prev_pres_r;
  assign out_ch.data.max_reorder_depth = longest_r;
  assign out_ch.data.min_delta         = least_r;
  assign out_ch.data.max_delta         = greatest_r;
  assign out_ch.data.delta_sum         = sum_r;
  assign out_ch.data.sample_count      = count_r;

endmodule

// ===== hdl/tss_checker.sv =====
// Port-level checks for the timestamp stream statistics core, with bind.
// Depends on tss_pkg and timestamp_stream_statistics_core.
module tss_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input tss_pkg::out_rsp_t out_data
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a decrease run never outgrows the number of samples seen
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.max_reorder_depth < out_data.sample_count) ||
                  (out_data.sample_count == tss_pkg::CNT_SAT))
    else $error("reorder depth exceeds sample count");

  // a positive minimum delta was seen, so the maximum covers it
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.min_delta > 0) &&
    (out_data.min_delta != tss_pkg::DELTA_MIN_INIT)
    |-> ({1'b0, out_data.max_delta} >= out_data.min_delta))
    else $error("max delta below a positive min delta");

endmodule

bind timestamp_stream_statistics_core tss_checker u_tss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timestamp_stream_statistics_core: random and directed timestamps,
// a statistics tracker class that predicts and checks every result.
// Depends on tss_pkg, tss_stream_if and the core.

module tb_top;
  import tss_pkg::*;

  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the pipeline
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before we give up
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 10;    // settling time after the last expected result
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_ITEMS  = 200;   // final stretch runs with no idling

  // Tracks stream state exactly as the core should and compares each result
  // against the oldest predicted statistics.
  class ts_stats_tracker;
    logic [OFS_W-1:0]        first_ofs;
    logic [TS_W-1:0]         last_comp;
    logic [TS_W-1:0]         last_pres;
    logic [CNT_W-1:0]        run_len;
    logic [CNT_W-1:0]        longest;
    logic signed [OFS_W-1:0] least;
    logic [DMAX_W-1:0]       greatest;
    logic [SUM_W-1:0]        sum;
    logic [CNT_W-1:0]        count;
    out_rsp_t                expected_stats[$];
    int                      mismatches;

    function new();
      first_ofs   = '0;
      last_comp   = '0;
      last_pres   = '0;
      mismatches  = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      run_len  = '0;
      longest  = '0;
      least    = DELTA_MIN_INIT;
      greatest = '0;
      sum      = '0;
      count    = '0;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t                exp;
      logic [TS_W-1:0]         ofs_ext;
      logic [TS_W-1:0]         first_ext;
      logic [TS_W-1:0]         step;
      logic signed [OFS_W-1:0] d;
      ofs_ext = {{(TS_W-OFS_W){req.comp_offset[OFS_W-1]}}, req.comp_offset};
      exp.comp_time = req.decode_time + ofs_ext;
      // start latches the offset and wipes statistics before counting itself
      if (req.start_of_stream) begin
        first_ofs = req.comp_offset;
        clear_stats();
      end
      first_ext = {{(TS_W-OFS_W){first_ofs[OFS_W-1]}}, first_ofs};
      exp.pres_time = exp.comp_time - first_ext;
      if (!req.start_of_stream) begin
        // delta is the low 32 bits of the 48-bit difference, read as signed
        step = exp.pres_time - last_pres;
        d = step[OFS_W-1:0];
        if (last_comp > exp.comp_time) begin
          if (run_len != CNT_SAT) run_len = run_len + 1'b1;
          if (run_len > longest) longest = run_len;
        end else begin
          run_len = '0;
        end
        if (d < least) least = d;
        if (d > 0 && d[DMAX_W-1:0] > greatest) greatest = d[DMAX_W-1:0];
        sum = sum + {{(SUM_W-OFS_W){d[OFS_W-1]}}, d};
      end
      if (count != CNT_SAT) count = count + 1'b1;
      last_comp = exp.comp_time;
      last_pres = exp.pres_time;
      exp.max_reorder_depth = longest;
      exp.min_delta         = least;
      exp.max_delta         = greatest;
      exp.delta_sum         = sum;
      exp.sample_count      = count;
      expected_stats.push_back(exp);
    endfunction

    function void field_check(string name, logic [63:0] exp, logic [63:0] got);
      if (exp !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t exp;
      if (expected_stats.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      exp = expected_stats.pop_front();
      field_check("comp_time", exp.comp_time, got.comp_time);
      field_check("pres_time", exp.pres_time, got.pres_time);
      field_check("max_reorder_depth", exp.max_reorder_depth, got.max_reorder_depth);
      field_check("min_delta", exp.min_delta, got.min_delta);
      field_check("max_delta", exp.max_delta, got.max_delta);
      field_check("delta_sum", exp.delta_sum, got.delta_sum);
      field_check("sample_count", exp.sample_count, got.sample_count);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tss_stream_if #(.T(in_req_t))  in_ch();
  tss_stream_if #(.T(out_rsp_t)) out_ch();

  timestamp_stream_statistics_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  ts_stats_tracker tracker = new();

  bit hold_results = 1'b0;  // main raises, receiver clears after its hold-off
  bit quiet        = 1'b0;  // no idling on either side
  int stall_cycles = 0;

  // sender idling: bursty stretches alternate with clean ones
  int tx_pct     = 0;
  int tx_stretch = 0;

  // synthetic stream: steady decode cadence, offsets shaped for reorder runs
  logic [TS_W-1:0]         strm_dts;
  logic [TS_W-1:0]         strm_dur;
  logic signed [OFS_W-1:0] strm_base;
  logic signed [OFS_W-1:0] strm_ofs;
  int                      strm_left = 0;
  int                      strm_run  = 0;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge, plus the stall watchdog.
  // Requests are noted before results so a same-edge pair stays ordered.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) tracker.note_request(in_ch.data);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) tracker.check_result(out_ch.data);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drives out_ch.ready at falling edges. Random stall bursts of random
  // length inside stretches of varying density; a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int rx_pct;
    int rx_stretch;
    int n;
    rx_pct     = 0;
    rx_stretch = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        // back-pressure long enough that the core stops taking requests
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        if (rx_stretch == 0) begin
          rx_stretch = $urandom_range(30, 150);
          case ($urandom_range(0, 2))
            0:       rx_pct = 0;
            1:       rx_pct = 15;
            default: rx_pct = 40;
          endcase
        end
        rx_stretch--;
        if (!quiet && $urandom_range(0, 99) < rx_pct) begin
          n = $urandom_range(1, 7);
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end else begin
          out_ch.ready <= 1'b1;
          @(negedge clk);
        end
      end
    end
  end

  // Offer one request from a falling edge; return at the falling edge after
  // it was taken, so the next call or gap drives valid exactly once.
  task automatic send_req(input in_req_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic tx_gap();
    int n;
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(30, 150);
      case ($urandom_range(0, 2))
        0:       tx_pct = 0;
        1:       tx_pct = 15;
        default: tx_pct = 40;
      endcase
    end
    tx_stretch--;
    if (!quiet && $urandom_range(0, 99) < tx_pct) begin
      n = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic in_req_t mk_req(bit s, logic [TS_W-1:0] t, logic [OFS_W-1:0] o);
    in_req_t r;
    r.start_of_stream = s;
    r.decode_time     = t;
    r.comp_offset     = o;
    return r;
  endfunction

  // Anything goes: full-range fields, start now and then in mid-stream.
  function automatic in_req_t noise_req();
    return mk_req($urandom_range(0, 7) == 0, {16'($urandom), 32'($urandom)}, $urandom);
  endfunction

  // Well-formed stream: start, then samples at a fixed cadence. Occasionally the
  // offset jumps up and steps down by two frames per sample, giving a run of
  // composition-time decreases (B-frame style reordering).
  function automatic in_req_t stream_req();
    in_req_t r;
    r.start_of_stream = 1'b0;
    if (strm_left == 0) begin
      strm_left = $urandom_range(8, 80);
      case ($urandom_range(0, 5))
        0:       strm_dur = 1;
        1:       strm_dur = 1001;
        2:       strm_dur = 512;
        3:       strm_dur = 3000;
        4:       strm_dur = TS_W'($urandom_range(1, 1 << 20));
        default: strm_dur = TS_W'($urandom);  // deltas that wrap the 32-bit view
      endcase
      if ($urandom_range(0, 3) == 0)
        strm_dts = {TS_W{1'b1}} - TS_W'($urandom_range(0, 5000));  // near the wrap
      else
        strm_dts = {16'($urandom), 32'($urandom)};
      case ($urandom_range(0, 4))
        0:       strm_base = 32'sh8000_0000;
        1:       strm_base = 32'sh7FFF_FFFF;
        2:       strm_base = $urandom;
        default: strm_base = OFS_W'($urandom_range(0, 8192)) - 32'sd4096;
      endcase
      strm_ofs = strm_base;
      strm_run = 0;
      r.start_of_stream = 1'b1;
    end else begin
      strm_dts = strm_dts + strm_dur;
      if (strm_run > 0) begin
        strm_ofs = strm_ofs - OFS_W'(2 * strm_dur);
        strm_run--;
      end else if ($urandom_range(0, 4) == 0) begin
        strm_run = $urandom_range(1, 6);
        strm_ofs = strm_base + OFS_W'((strm_run + 1) * 2 * strm_dur);
      end else begin
        strm_ofs = strm_base + OFS_W'($urandom_range(0, 2) * strm_dur);
      end
    end
    strm_left--;
    r.decode_time = strm_dts;
    r.comp_offset = strm_ofs;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed corners, back-pressure, pause, random mix.
  // ---------------------------------------------------------------------------
  initial begin
    in_req_t dir_reqs[$];
    int      waited;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // samples before any start run on reset state (offset 0, previous 0)
    dir_reqs.push_back(mk_req(1'b0, '0, '0));
    dir_reqs.push_back(mk_req(1'b0, {TS_W{1'b1}}, 32'hFFFF_FFFF));
    dir_reqs.push_back(mk_req(1'b0, 48'd5, 32'h8000_0000));
    // start with the largest offset, then a two-deep decrease run
    dir_reqs.push_back(mk_req(1'b1, 48'd1000, 32'h7FFF_FFFF));
    dir_reqs.push_back(mk_req(1'b0, 48'd2000, 32'h7FFF_FFFF));
    dir_reqs.push_back(mk_req(1'b0, 48'd1500, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'd1400, '0));
    dir_reqs.push_back(mk_req(1'b0, '0, 32'h8000_0000));
    dir_reqs.push_back(mk_req(1'b0, {TS_W{1'b1}}, 32'h7FFF_FFFF));
    // deltas of exactly 2^31 read as the most negative value, then 0 and 2^31-1
    dir_reqs.push_back(mk_req(1'b1, '0, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'h0000_8000_0000, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'h0001_0000_0000, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'h0001_0000_0000, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'h0001_7FFF_FFFF, '0));
    // back-to-back starts, then a wrap past 2^48
    dir_reqs.push_back(mk_req(1'b1, {TS_W{1'b1}}, 32'hFFFF_FFFF));
    dir_reqs.push_back(mk_req(1'b1, {TS_W{1'b1}}, 32'hFFFF_FFFF));
    dir_reqs.push_back(mk_req(1'b0, '0, '0));
    dir_reqs.push_back(mk_req(1'b0, 48'h5555_5555_5555, 32'h5555_5555));
    dir_reqs.push_back(mk_req(1'b0, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA));
    dir_reqs.push_back(mk_req(1'b0, 48'd1, 32'd1));
    foreach (dir_reqs[i]) begin
      send_req(dir_reqs[i]);
      tx_gap();
    end

    // keep offering while results are held back; the core must stall its input
    hold_results = 1'b1;
    repeat (40) send_req(stream_req());

    // sender pause until every outstanding result is out
    in_ch.valid <= 1'b0;
    while (tracker.expected_stats.size() != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send_req(noise_req());
      else
        send_req(stream_req());
      tx_gap();
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (tracker.expected_stats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (tracker.mismatches == 0 && tracker.expected_stats.size() == 0) begin
      $display("status: pass");
    end else begin
      if (tracker.expected_stats.size() != 0)
        $display("%0t: %0d results never arrived", $time, tracker.expected_stats.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tss_pkg.sv
hdl/tss_stream_if.sv
hdl/timestamp_stream_statistics_core.sv
hdl/tss_checker.sv
tb/tb_top.sv
